FILE: rtl/core/fwa_pkg.sv
`timescale 1ns / 1ps

package fwa_pkg;

    // Fixed field widths of the configuration registers and result fields.
    localparam int FRAME_LENGTH_W  = 13;
    localparam int WINDOW_LENGTH_W = 5;
    localparam int SAMPLE_W        = 32;
    localparam int ELEM_INDEX_W    = 12;

    // Reset values of the configuration registers.
    localparam logic [FRAME_LENGTH_W-1:0]  FRAME_LENGTH_RST  = 13'd4096;
    localparam logic [WINDOW_LENGTH_W-1:0] WINDOW_LENGTH_RST = 5'd10;
    localparam int                         WINDOW_RST_INT    = 10;

    // The frame count saturates here and never needs more than five bits.
    localparam int FS_MIN_W = 5;
    localparam int FS_SAT   = 31;

    // Depth of the operation queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register indexes on the configuration port.
    localparam int CFG_ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_FRAME_LENGTH  = 2'd0,
        REG_WINDOW_LENGTH = 2'd1,
        REG_ROLLING_MODE  = 2'd2
    } cfg_reg_t;

    // Control flags the front part attaches to each element it hands on.
    typedef struct packed {
        logic fresh;    // overwrite the running sum instead of adding to it
        logic sub_hist; // subtract the oldest history element
        logic hist_we;  // store the element in the history
        logic emit;     // produce a result word for this element
        logic last;     // final element of the frame
    } op_ctrl_t;

endpackage

FILE: rtl/core/frame_window_accumulator_top.sv
`timescale 1ns / 1ps

// Frame window accumulator.
// The input stream carries one word per frame element: s_tdata is the signed
// 32-bit sample and s_tuser is the command, 0 for an element and 1 for a restart
// that clears all sums, the history and the frame counters and gives no result.
// The result stream carries one word per element of an emitted frame: the
// wrapping 32-bit sum and the element index in m_tdata, with m_tlast on the
// final element. In block mode only the last frame of each block is emitted;
// in rolling mode every frame is emitted, the first ones over a partly filled window.
// Frame length, window length and mode are set through the APB port while the
// block is idle. A result passes through the queue, the update stage and the
// output register; the block sustains one element per cycle unless the
// receiver stalls. The per-element sum memory takes one read and one write per
// cycle and the history memory one read and one write, which sets that rate. After
// reset the configuration holds its default values and the next element starts a
// fresh block; the memories are not cleared, as stale entries are never used. When
// the receiver stalls, a four-word queue, the update stage and the output register
// absorb the backlog before s_tready falls.
module frame_window_accumulator_top #(
    parameter int MAX_FRAME_ELEMENTS = 4096,
    parameter int MAX_WINDOW         = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fwa_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // [31:0] sample_value
    input  logic                              s_tuser,  // [0] command
    // Result stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,  // [31:0] sum_value, [43:32] element_index
    output logic                              m_tlast
);
    import fwa_pkg::*;

    localparam int IDX_W  = (MAX_FRAME_ELEMENTS > 1) ? $clog2(MAX_FRAME_ELEMENTS) : 1;
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [FRAME_LENGTH_W-1:0]  frame_length_reg;
    logic [WINDOW_LENGTH_W-1:0] window_length_reg;
    logic                       rolling_mode_reg;
    logic                       cfg_write;
    cfg_reg_t                   cfg_index;

    // Push side of the queue, written by the front part.
    logic                f_push;
    op_ctrl_t            f_ctrl;
    logic [IDX_W-1:0]    f_idx;
    logic [SLOT_W-1:0]   f_slot;
    logic [SAMPLE_W-1:0] f_value;
    logic                q_full;

    // Pop side of the queue, read by the back part.
    logic                q_valid;
    logic                q_pop;
    op_ctrl_t            q_ctrl;
    logic [IDX_W-1:0]    q_idx;
    logic [SLOT_W-1:0]   q_slot;
    logic [SAMPLE_W-1:0] q_value;

    logic [SAMPLE_W-1:0]     m_sum;
    logic [ELEM_INDEX_W-1:0] m_index;

    // Registers sit at byte addresses 0, 4 and 8; a write lands in the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_length_reg  <= FRAME_LENGTH_RST;
            window_length_reg <= WINDOW_LENGTH_RST;
            rolling_mode_reg  <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_FRAME_LENGTH: begin
                    frame_length_reg <= pwdata[FRAME_LENGTH_W-1:0];
                end
                REG_WINDOW_LENGTH: begin
                    window_length_reg <= pwdata[WINDOW_LENGTH_W-1:0];
                end
                REG_ROLLING_MODE: begin
                    rolling_mode_reg <= pwdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_FRAME_LENGTH:  prdata = 32'(frame_length_reg);
            REG_WINDOW_LENGTH: prdata = 32'(window_length_reg);
            REG_ROLLING_MODE:  prdata = 32'(rolling_mode_reg);
            default:           prdata = '0;
        endcase
    end

    // The front part tracks the frame position and the window, and decides
    // for every element whether it starts a fresh sum, subtracts history and
    // is emitted. Restarts end there.
    fwa_front #(
        .MAX_FRAME_ELEMENTS (MAX_FRAME_ELEMENTS),
        .MAX_WINDOW         (MAX_WINDOW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frame_length  (frame_length_reg),
        .window_length (window_length_reg),
        .rolling_mode  (rolling_mode_reg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tuser       (s_tuser),
        .s_tdata       (s_tdata),
        .q_full        (q_full),
        .q_push        (f_push),
        .q_ctrl        (f_ctrl),
        .q_idx         (f_idx),
        .q_slot        (f_slot),
        .q_value       (f_value)
    );

    fwa_queue #(
        .IDX_W  (IDX_W),
        .SLOT_W (SLOT_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_push   (f_push),
        .in_ctrl   (f_ctrl),
        .in_idx    (f_idx),
        .in_slot   (f_slot),
        .in_value  (f_value),
        .full      (q_full),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_ctrl  (q_ctrl),
        .out_idx   (q_idx),
        .out_slot  (q_slot),
        .out_value (q_value)
    );

    // The back part reads the sum and history memories, updates the sum and
    // holds the result word until the receiver takes it.
    fwa_back #(
        .MAX_FRAME_ELEMENTS (MAX_FRAME_ELEMENTS),
        .MAX_WINDOW         (MAX_WINDOW)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_ctrl   (q_ctrl),
        .q_idx    (q_idx),
        .q_slot   (q_slot),
        .q_value  (q_value),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_sum    (m_sum),
        .m_index  (m_index),
        .m_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, m_index, m_sum};

endmodule

FILE: rtl/core/fwa_ram.sv
`timescale 1ns / 1ps

module fwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read and a write to the same address in one cycle return the old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/fwa_front.sv
`timescale 1ns / 1ps

module fwa_front #(
    parameter int MAX_FRAME_ELEMENTS = 4096,
    parameter int MAX_WINDOW         = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [fwa_pkg::FRAME_LENGTH_W-1:0]            frame_length,
    input  logic [fwa_pkg::WINDOW_LENGTH_W-1:0]           window_length,
    input  logic                                          rolling_mode,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    input  logic                                          s_tuser,
    input  logic [fwa_pkg::SAMPLE_W-1:0]                  s_tdata,
    input  logic                                          q_full,
    output logic                                          q_push,
    output fwa_pkg::op_ctrl_t                             q_ctrl,
    output logic [((MAX_FRAME_ELEMENTS > 1) ? $clog2(MAX_FRAME_ELEMENTS) : 1)-1:0] q_idx,
    output logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] q_slot,
    output logic [fwa_pkg::SAMPLE_W-1:0]                  q_value
);
    import fwa_pkg::*;

    localparam int IDX_W  = (MAX_FRAME_ELEMENTS > 1) ? $clog2(MAX_FRAME_ELEMENTS) : 1;
    localparam int LEN_W  = $clog2(MAX_FRAME_ELEMENTS + 1);
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int W_W    = $clog2(MAX_WINDOW + 1);
    localparam int FS_W   = (W_W > FS_MIN_W) ? W_W : FS_MIN_W;
    localparam int RST_WINDOW = (WINDOW_RST_INT > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RST_INT;

    logic [IDX_W-1:0]      ec_reg, ec_next;
    logic [FS_W-1:0]       fs_reg, fs_next;
    logic [SLOT_W-1:0]     hs_reg, hs_next;
    logic [MAX_WINDOW-1:0] valid_reg, valid_next;
    logic                  fresh_reg, fresh_next;

    logic [LEN_W-1:0]  eff_len;
    logic [W_W-1:0]    eff_win;
    logic              accept;
    logic              restart;
    logic [FS_W-1:0]   fs_mid;
    logic [SLOT_W-1:0] hs_mid;
    logic              fresh_mid;
    logic              last;
    logic              emit;

    always_comb begin
        if (frame_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(frame_length) > MAX_FRAME_ELEMENTS) begin
            eff_len = LEN_W'(MAX_FRAME_ELEMENTS);
        end else begin
            eff_len = LEN_W'(frame_length);
        end
        if (window_length == '0) begin
            eff_win = W_W'(1);
        end else if (int'(window_length) > MAX_WINDOW) begin
            eff_win = W_W'(MAX_WINDOW);
        end else begin
            eff_win = W_W'(window_length);
        end
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign restart  = accept && s_tuser;

    // Frame start: wrap the history slot, clamp the count or reset it and set fresh.
    always_comb begin
        fs_mid    = fs_reg;
        hs_mid    = hs_reg;
        fresh_mid = fresh_reg;
        if (ec_reg == '0) begin
            if (rolling_mode) begin
                if (W_W'(hs_reg) >= eff_win) begin
                    hs_mid = '0;
                end
                if (fs_reg >= FS_W'(eff_win)) begin
                    fs_mid = FS_W'(eff_win) - FS_W'(1);
                end
            end else if (fs_reg >= FS_W'(eff_win)) begin
                fs_mid    = '0;
                fresh_mid = 1'b1;
            end
        end
        last = (LEN_W'(ec_reg) + LEN_W'(1)) >= eff_len;
        emit = ((FS_W + 1)'(fs_mid) + (FS_W + 1)'(1)) >= (FS_W + 1)'(eff_win);
    end

    always_comb begin
        ec_next    = ec_reg;
        fs_next    = fs_reg;
        hs_next    = hs_reg;
        valid_next = valid_reg;
        fresh_next = fresh_reg;
        if (restart) begin
            ec_next    = '0;
            fs_next    = FS_W'(eff_win);
            hs_next    = '0;
            valid_next = '0;
            fresh_next = 1'b1;
        end else if (accept) begin
            fs_next    = fs_mid;
            hs_next    = hs_mid;
            fresh_next = fresh_mid;
            if (last) begin
                ec_next    = '0;
                fresh_next = 1'b0;
                if (int'(fs_mid) < FS_SAT) begin
                    fs_next = fs_mid + FS_W'(1);
                end
                if (rolling_mode) begin
                    valid_next[hs_mid] = 1'b1;
                    if ((W_W'(hs_mid) + W_W'(1)) >= eff_win) begin
                        hs_next = '0;
                    end else begin
                        hs_next = hs_mid + SLOT_W'(1);
                    end
                end
            end else begin
                ec_next = ec_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ec_reg    <= '0;
            fs_reg    <= FS_W'(RST_WINDOW);
            hs_reg    <= '0;
            valid_reg <= '0;
            fresh_reg <= 1'b1;
        end else begin
            ec_reg    <= ec_next;
            fs_reg    <= fs_next;
            hs_reg    <= hs_next;
            valid_reg <= valid_next;
            fresh_reg <= fresh_next;
        end
    end

    assign q_push           = accept && !s_tuser;
    assign q_ctrl.fresh     = fresh_mid;
    assign q_ctrl.sub_hist  = rolling_mode && valid_reg[hs_mid];
    assign q_ctrl.hist_we   = rolling_mode;
    assign q_ctrl.emit      = emit;
    assign q_ctrl.last      = last;
    assign q_idx            = ec_reg;
    assign q_slot           = hs_mid;
    assign q_value          = s_tdata;

    // A restart leaves the block at the start of a fresh frame.
    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (ec_reg == '0) && fresh_reg && (valid_reg == '0))
        else $error("restart did not clear the frame state");

endmodule

FILE: rtl/core/fwa_queue.sv
`timescale 1ns / 1ps

module fwa_queue #(
    parameter int IDX_W  = 12,
    parameter int SLOT_W = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_push,
    input  fwa_pkg::op_ctrl_t             in_ctrl,
    input  logic [IDX_W-1:0]              in_idx,
    input  logic [SLOT_W-1:0]             in_slot,
    input  logic [fwa_pkg::SAMPLE_W-1:0]  in_value,
    output logic                          full,
    output logic                          out_valid,
    input  logic                          out_pop,
    output fwa_pkg::op_ctrl_t             out_ctrl,
    output logic [IDX_W-1:0]              out_idx,
    output logic [SLOT_W-1:0]             out_slot,
    output logic [fwa_pkg::SAMPLE_W-1:0]  out_value
);
    import fwa_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_ctrl_t            ctrl_reg  [QUEUE_DEPTH];
    logic [IDX_W-1:0]    idx_reg   [QUEUE_DEPTH];
    logic [SLOT_W-1:0]   slot_reg  [QUEUE_DEPTH];
    logic [SAMPLE_W-1:0] value_reg [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign do_push   = in_push && !full;
    assign do_pop    = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ctrl_reg[wr_ptr_reg]  <= in_ctrl;
            idx_reg[wr_ptr_reg]   <= in_idx;
            slot_reg[wr_ptr_reg]  <= in_slot;
            value_reg[wr_ptr_reg] <= in_value;
        end
    end

    assign out_ctrl  = ctrl_reg[rd_ptr_reg];
    assign out_idx   = idx_reg[rd_ptr_reg];
    assign out_slot  = slot_reg[rd_ptr_reg];
    assign out_value = value_reg[rd_ptr_reg];

    // The front part must never offer an element when the queue is full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_push |-> !full)
        else $error("element pushed into a full queue");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("queue count lost a push");

endmodule

FILE: rtl/core/fwa_back.sv
`timescale 1ns / 1ps

module fwa_back #(
    parameter int MAX_FRAME_ELEMENTS = 4096,
    parameter int MAX_WINDOW         = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_valid,
    output logic                                  q_pop,
    input  fwa_pkg::op_ctrl_t                     q_ctrl,
    input  logic [((MAX_FRAME_ELEMENTS > 1) ? $clog2(MAX_FRAME_ELEMENTS) : 1)-1:0] q_idx,
    input  logic [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] q_slot,
    input  logic [fwa_pkg::SAMPLE_W-1:0]          q_value,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [fwa_pkg::SAMPLE_W-1:0]          m_sum,
    output logic [fwa_pkg::ELEM_INDEX_W-1:0]      m_index,
    output logic                                  m_last
);
    import fwa_pkg::*;

    localparam int IDX_W  = (MAX_FRAME_ELEMENTS > 1) ? $clog2(MAX_FRAME_ELEMENTS) : 1;
    localparam int HDEPTH = MAX_FRAME_ELEMENTS * MAX_WINDOW;
    localparam int HA_W   = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;

    logic                issue;
    logic                b2_done;
    logic                out_free;
    logic [HA_W-1:0]     hist_addr;
    logic [SAMPLE_W-1:0] sum_rd;
    logic [SAMPLE_W-1:0] hist_rd;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] new_sum;

    logic                b2_valid_reg, b2_valid_next;
    op_ctrl_t            b2_ctrl_reg;
    logic [IDX_W-1:0]    b2_idx_reg;
    logic [SAMPLE_W-1:0] b2_value_reg;

    logic                lw_valid_reg;
    logic [IDX_W-1:0]    lw_idx_reg;
    logic [SAMPLE_W-1:0] lw_data_reg;

    logic                    m_valid_reg, m_valid_next;
    logic [SAMPLE_W-1:0]     m_sum_reg;
    logic [ELEM_INDEX_W-1:0] m_index_reg;
    logic                    m_last_reg;

    assign out_free = !m_valid_reg || m_tready;
    assign b2_done  = b2_valid_reg && (!b2_ctrl_reg.emit || out_free);
    assign issue    = q_valid && (!b2_valid_reg || b2_done);
    assign q_pop    = issue;

    assign hist_addr = HA_W'(q_slot) * HA_W'(MAX_FRAME_ELEMENTS) + HA_W'(q_idx);

    fwa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_FRAME_ELEMENTS)
    ) u_sum_ram (
        .aclk  (aclk),
        .we    (b2_done),
        .waddr (b2_idx_reg),
        .wdata (new_sum),
        .re    (issue),
        .raddr (q_idx),
        .rdata (sum_rd)
    );

    // The history entry is read, and in rolling mode replaced, in the same cycle.
    fwa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HDEPTH)
    ) u_hist_ram (
        .aclk  (aclk),
        .we    (issue && q_ctrl.hist_we),
        .waddr (hist_addr),
        .wdata (q_value),
        .re    (issue),
        .raddr (hist_addr),
        .rdata (hist_rd)
    );

    // The sum written last may not have reached the read data yet.
    always_comb begin
        if (b2_ctrl_reg.fresh) begin
            base = '0;
        end else if (lw_valid_reg && (lw_idx_reg == b2_idx_reg)) begin
            base = lw_data_reg;
        end else begin
            base = sum_rd;
        end
        if (b2_ctrl_reg.sub_hist) begin
            base = base - hist_rd;
        end
        new_sum = base + b2_value_reg;
    end

    always_comb begin
        b2_valid_next = b2_valid_reg;
        if (issue) begin
            b2_valid_next = 1'b1;
        end else if (b2_done) begin
            b2_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (b2_done && b2_ctrl_reg.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            b2_valid_reg <= b2_valid_next;
            m_valid_reg  <= m_valid_next;
            if (b2_done) begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            b2_ctrl_reg  <= q_ctrl;
            b2_idx_reg   <= q_idx;
            b2_value_reg <= q_value;
        end
        if (b2_done) begin
            lw_idx_reg  <= b2_idx_reg;
            lw_data_reg <= new_sum;
        end
        if (b2_done && b2_ctrl_reg.emit) begin
            m_sum_reg   <= new_sum;
            m_index_reg <= ELEM_INDEX_W'(b2_idx_reg);
            m_last_reg  <= b2_ctrl_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_sum    = m_sum_reg;
    assign m_index  = m_index_reg;
    assign m_last   = m_last_reg;

    // A stalled element must not be overtaken: its read data would be lost.
    a_no_issue_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_valid_reg && !b2_done) |-> !issue)
        else $error("new element issued while the update stage is stalled");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b2_valid_reg && !b2_done) |=> b2_valid_reg && $stable(b2_idx_reg))
        else $error("stalled element left the update stage");

endmodule
